// ===== design/srmt_pkg.sv =====
// ----------------------------------------------------------------------------
// srmt_pkg
// shared widths and constants of the sweep range max tracker
// ----------------------------------------------------------------------------
`default_nettype none

package srmt_pkg;

  // payload field widths
  localparam int unsigned RangeW   = 16;
  localparam int unsigned PosW     = 5;
  localparam int unsigned HeadingW = 8;

  // heading scale in degrees over the full sweep
  localparam int unsigned HeadingScale = 180;

endpackage : srmt_pkg

`default_nettype wire

// ===== design/srmt_if.sv =====
// ----------------------------------------------------------------------------
// srmt_in_if / srmt_out_if
// valid/ready channels carrying sample words in and result words out
// ----------------------------------------------------------------------------
`default_nettype none

interface srmt_in_if
  import srmt_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [RangeW-1:0] range_sample;

  modport source (output valid, output range_sample, input ready);
  modport sink   (input valid, input range_sample, output ready);
endinterface : srmt_in_if

interface srmt_out_if
  import srmt_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [PosW-1:0]     sample_position;
  logic                moving_right;
  logic                turn_request;
  logic [PosW-1:0]     farthest_position;
  logic [HeadingW-1:0] heading_degrees;
  logic [RangeW-1:0]   farthest_range;

  modport source (
    output valid, output sample_position, output moving_right, output turn_request,
    output farthest_position, output heading_degrees, output farthest_range,
    input ready
  );
  modport sink (
    input valid, input sample_position, input moving_right, input turn_request,
    input farthest_position, input heading_degrees, input farthest_range,
    output ready
  );
endinterface : srmt_out_if

`default_nettype wire

// ===== design/srmt_store.sv =====
// ----------------------------------------------------------------------------
// srmt_store
// sample memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module srmt_store
  import srmt_pkg::*;
#(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire logic [RangeW-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output logic      [RangeW-1:0] rdata_o
);

  logic [RangeW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule : srmt_store

`default_nettype wire

// ===== design/srmt_heading.sv =====
// ----------------------------------------------------------------------------
// srmt_heading
// position*180/(POINTS-1) by a constant reciprocal multiply, registered on start
// ----------------------------------------------------------------------------
`default_nettype none

module srmt_heading
  import srmt_pkg::*;
#(
  parameter int unsigned Points = 32,
  parameter int unsigned AddrW  = 5
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [AddrW-1:0]    position_i,
  output logic      [HeadingW-1:0] degrees_o
);

  // numerator position*180 fits AddrW + HeadingW bits
  localparam int unsigned NumW  = AddrW + HeadingW;
  localparam int unsigned Div   = Points - 1;
  // ceil(2^Shift / Div) gives the exact floor for every numerator below 2^NumW
  localparam int unsigned Shift = NumW + $clog2(Div);
  localparam int unsigned MulW  = NumW + 1;
  localparam int unsigned ProdW = NumW + MulW;
  localparam longint unsigned MulVal =
    ((64'd1 << Shift) + 64'(Div) - 64'd1) / 64'(Div);
  localparam logic [MulW-1:0] Mul = MulW'(MulVal);

  logic [NumW-1:0]     num;
  logic [ProdW-1:0]    prod;
  logic [HeadingW-1:0] deg_q, deg_d;

  assign num   = NumW'(position_i) * NumW'(HeadingScale);
  assign prod  = ProdW'(num) * ProdW'(Mul);
  assign deg_d = start_i ? prod[Shift +: HeadingW] : deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q <= '0;
    end else begin
      deg_q <= deg_d;
    end
  end

  assign degrees_o = deg_q;

endmodule : srmt_heading

`default_nettype wire

// ===== design/sweep_range_max_tracker.sv =====
// ----------------------------------------------------------------------------
// sweep_range_max_tracker
// stores range samples of a back-and-forth sweep and tracks the farthest one
// ----------------------------------------------------------------------------
//
//  port       | dir | words
//  -----------+-----+----------------------------------------------------------
//  in_ch_i    | in  | range_sample, one per sweep position
//  out_ch_o   | out | position, direction, turn, farthest position/heading/range
//
//  after reset a clearing pass writes zero to all POINTS memory entries,
//  with in ready held low throughout the pass
//  an item that does not hit the stored maximum is accepted with the
//  heading registered, then loaded into the output register
//  an item that overwrites the maximum adds a rescan that reads all POINTS
//  entries through the single read port of the sample memory
//  one item at a time; the output register lets the next word in while a
//  result waits, and a full output register stalls the finished item
//
`default_nettype none

module sweep_range_max_tracker
  import srmt_pkg::*;
#(
  parameter int unsigned POINTS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  srmt_in_if.sink          in_ch_i,
  srmt_out_if.source       out_ch_o
);

  localparam int unsigned AddrW = $clog2(POINTS);
  localparam int unsigned CntW  = $clog2(POINTS + 1);
  localparam logic [AddrW-1:0] LastPos = AddrW'(POINTS - 1);
  localparam logic [CntW-1:0]  CntEnd  = CntW'(POINTS);

  // control states
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StDone  = 3'd3;

  logic [2:0]        state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;          // clearing pass address
  logic [AddrW-1:0]  pos_q, pos_d;          // sweep position of the next word
  logic              dir_q, dir_d;          // sweep direction, 1 increasing
  logic [AddrW-1:0]  best_q, best_d;        // position of the stored maximum
  logic [RangeW-1:0] best_val_q, best_val_d; // copy of the sample at best_q
  logic [AddrW-1:0]  cur_pos_q, cur_pos_d;  // position of the word in flight
  logic              cur_dir_q, cur_dir_d;
  logic              turn_q, turn_d;
  logic [CntW-1:0]   scan_q, scan_d;        // rescan read issue count
  logic              rd_vld_q;              // memory read data valid
  logic [AddrW-1:0]  rd_idx_q;              // address of that read data
  logic [RangeW-1:0] top_q, top_d;          // largest value seen by the rescan

  logic              out_vld_q, out_vld_d;
  logic [PosW-1:0]     o_pos_q, o_best_q;
  logic              o_dir_q, o_turn_q;
  logic [HeadingW-1:0] o_head_q;
  logic [RangeW-1:0] o_range_q;
  logic              out_load;

  // memory ports
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [RangeW-1:0] mem_wdata;
  logic              mem_re;
  logic [RangeW-1:0] mem_rdata;

  // heading by reciprocal multiply, registered on start
  logic              div_start;
  logic [HeadingW-1:0] div_deg;

  logic              in_acc;
  logic              dir_now;
  logic              scan_issue;

  assign in_ch_i.ready = (state_q == StIdle);
  assign in_acc        = in_ch_i.valid && in_ch_i.ready;

  // bounce at both ends before the sample is stored
  always_comb begin
    priority if (pos_q == LastPos) begin
      dir_now = 1'b0;
    end else if (pos_q == '0) begin
      dir_now = 1'b1;
    end else begin
      dir_now = dir_q;
    end
  end

  assign scan_issue = (state_q == StScan) && (scan_q != CntEnd);
  assign mem_re     = scan_issue;
  assign out_load   = (state_q == StDone) && (!out_vld_q || out_ch_o.ready);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    pos_d      = pos_q;
    dir_d      = dir_q;
    best_d     = best_q;
    best_val_d = best_val_q;
    cur_pos_d  = cur_pos_q;
    cur_dir_d  = cur_dir_q;
    turn_d     = turn_q;
    scan_d     = scan_q;
    top_d      = top_q;
    div_start  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = pos_q;
    mem_wdata  = in_ch_i.range_sample;

    unique case (state_q)
      StClear: begin
        // zero every entry once after reset
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LastPos) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_acc) begin
          mem_we    = 1'b1;
          cur_pos_d = pos_q;
          cur_dir_d = dir_now;
          dir_d     = dir_now;
          pos_d     = dir_now ? pos_q + 1'b1 : pos_q - 1'b1;
          turn_d    = 1'b0;
          if (pos_q == best_q) begin
            // maximum overwritten by a new value, larger or not: rescan
            scan_d  = '0;
            top_d   = '0;
            state_d = StScan;
          end else begin
            if (in_ch_i.range_sample > best_val_q) begin
              best_d     = pos_q;
              best_val_d = in_ch_i.range_sample;
              turn_d     = 1'b1;
            end
            div_start = 1'b1;
            state_d   = StDone;
          end
        end
      end
      StScan: begin
        if (scan_issue) begin
          scan_d = scan_q + 1'b1;
        end
        // strict compare keeps the lowest position among equal values
        if (rd_vld_q && (mem_rdata > top_q)) begin
          top_d  = mem_rdata;
          best_d = rd_idx_q;
        end
        if (rd_vld_q && !scan_issue) begin
          best_val_d = (mem_rdata > top_q) ? mem_rdata : top_q;
          div_start  = 1'b1;
          state_d    = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_ch_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      clr_q      <= '0;
      pos_q      <= '0;
      dir_q      <= 1'b1;
      best_q     <= '0;
      best_val_q <= '0;
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      pos_q      <= pos_d;
      dir_q      <= dir_d;
      best_q     <= best_d;
      best_val_q <= best_val_d;
      scan_q     <= scan_d;
      rd_vld_q   <= scan_issue;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_pos_q <= cur_pos_d;
    cur_dir_q <= cur_dir_d;
    turn_q    <= turn_d;
    top_q     <= top_d;
    rd_idx_q  <= scan_q[AddrW-1:0];
    if (out_load) begin
      o_pos_q   <= PosW'(cur_pos_q);
      o_dir_q   <= cur_dir_q;
      o_turn_q  <= turn_q;
      o_best_q  <= PosW'(best_q);
      o_head_q  <= div_deg;
      o_range_q <= best_val_q;
    end
  end

  srmt_store #(
    .Depth (POINTS),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (scan_q[AddrW-1:0]),
    .rdata_o (mem_rdata)
  );

  srmt_heading #(
    .Points (POINTS),
    .AddrW  (AddrW)
  ) u_heading (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .position_i (best_d),
    .degrees_o  (div_deg)
  );

  assign out_ch_o.valid             = out_vld_q;
  assign out_ch_o.sample_position   = o_pos_q;
  assign out_ch_o.moving_right      = o_dir_q;
  assign out_ch_o.turn_request      = o_turn_q;
  assign out_ch_o.farthest_position = o_best_q;
  assign out_ch_o.heading_degrees   = o_head_q;
  assign out_ch_o.farthest_range    = o_range_q;

  // a new maximum is always the position just written
  a_turn_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch_o.valid && out_ch_o.turn_request |->
      out_ch_o.farthest_position == out_ch_o.sample_position)
    else $error("turn request with farthest position off the written one");

  // heading stays within the half circle
  a_head_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch_o.valid |-> out_ch_o.heading_degrees <= HeadingW'(HeadingScale))
    else $error("heading above 180 degrees");

  // no read data arrives outside a rescan
  a_rd_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == StScan)
    else $error("memory read outside rescan");

endmodule : sweep_range_max_tracker

`default_nettype wire
